[rtl/core/base64_stream_codec_defines.svh]
// Assertion macros for the base64 stream codec RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH
`ifndef SYNTH
`define B64SC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B64SC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define B64SC_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64SC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/b64sc_pkg.sv]
// Shared types, character constants and alphabet functions for the base64 codec.
// No dependencies; used by b64sc_core, b64sc_out_buf and base64_stream_codec.
package b64sc_pkg;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       length_error;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [CntW-1:0]   cnt;
  } group_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = CH_UPPER_A + {2'b00, v};
      [6'd26:6'd51]: c = CH_LOWER_A + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = CH_DIGIT_0 + {2'b00, v} - 8'd52;
      6'd62:         c = CH_PLUS;
      default:       c = CH_SLASH;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    logic [7:0] s;
    case (c) inside
      [CH_UPPER_A:CH_UPPER_Z]: s = c - CH_UPPER_A;
      [CH_LOWER_A:CH_LOWER_Z]: s = c - CH_LOWER_A + 8'd26;
      [CH_DIGIT_0:CH_DIGIT_9]: s = c - CH_DIGIT_0 + 8'd52;
      CH_PLUS:                 s = 8'd62;
      CH_SLASH:                s = 8'd63;
      default:                 s = 8'd0;
    endcase
    return s[5:0];
  endfunction

endpackage

[rtl/core/b64sc_if.sv]
// Valid/ready request channels of the base64 codec: input items and results.
// Depends on nothing; payload widths are fixed by the codec's fields.
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;
  modport source (output valid, in_byte, last, input ready);
  modport sink (input valid, in_byte, last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       length_error;
  modport source (output valid, out_byte, out_last, length_error, input ready);
  modport sink (input valid, out_byte, out_last, length_error, output ready);
endinterface

[rtl/core/b64sc_core.sv]
// Group state and single-pass encode/decode logic for one request.
// Depends on b64sc_pkg and base64_stream_codec_defines.svh.
`include "base64_stream_codec_defines.svh"
module b64sc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                fire_i,
  input  b64sc_pkg::item_t    item_i,
  output b64sc_pkg::group_t   grp_o
);

  logic        mode_q, mode_d;
  logic [1:0]  pos_q, pos_d;
  logic [17:0] acc_q, acc_d;
  logic        pad_q, pad_d;

  logic [1:0]  n_pos;
  logic [17:0] n_acc;
  logic        n_pad;
  logic [5:0]  sx;
  logic [23:0] triple;
  logic [7:0]  b;
  logic        fin;
  logic        is_pad;
  logic [2:0]  dcnt;
  b64sc_pkg::group_t grp;

  always_comb begin
    grp    = '0;
    b      = item_i.in_byte;
    fin    = item_i.last;
    sx     = b64sc_pkg::b64_sextet(b);
    triple = {acc_q, sx};
    is_pad = (b == b64sc_pkg::CH_PAD);
    dcnt   = 3'd3 - {2'b00, fin && is_pad} - {2'b00, fin && pad_q};
    n_pos  = pos_q;
    n_acc  = acc_q;
    n_pad  = pad_q;
    if (mode_q == b64sc_pkg::MODE_ENCODE) begin
      n_pad = 1'b0;
      case (pos_q)
        2'd1: begin
          grp.ent[0].out_byte = b64sc_pkg::b64_char({acc_q[1:0], b[7:4]});
          n_acc = {14'd0, b[3:0]};
          n_pos = 2'd2;
          grp.cnt = 3'd1;
          if (fin) begin
            grp.ent[1].out_byte = b64sc_pkg::b64_char({b[3:0], 2'b00});
            grp.ent[2].out_byte = b64sc_pkg::CH_PAD;
            grp.ent[2].out_last = 1'b1;
            grp.cnt = 3'd3;
          end
        end
        2'd2: begin
          grp.ent[0].out_byte = b64sc_pkg::b64_char({acc_q[3:0], b[7:6]});
          grp.ent[1].out_byte = b64sc_pkg::b64_char(b[5:0]);
          grp.ent[1].out_last = fin;
          n_acc = '0;
          n_pos = 2'd0;
          grp.cnt = 3'd2;
        end
        default: begin
          grp.ent[0].out_byte = b64sc_pkg::b64_char(b[7:2]);
          n_acc = {16'd0, b[1:0]};
          n_pos = 2'd1;
          grp.cnt = 3'd1;
          if (fin) begin
            grp.ent[1].out_byte = b64sc_pkg::b64_char({b[1:0], 4'b0000});
            grp.ent[2].out_byte = b64sc_pkg::CH_PAD;
            grp.ent[3].out_byte = b64sc_pkg::CH_PAD;
            grp.ent[3].out_last = 1'b1;
            grp.cnt = 3'd4;
          end
        end
      endcase
    end else if (pos_q != 2'd3) begin
      if (fin) begin
        grp.ent[0].out_last     = 1'b1;
        grp.ent[0].length_error = 1'b1;
        grp.cnt = 3'd1;
      end else begin
        n_acc = {acc_q[11:0], sx};
        n_pos = pos_q + 2'd1;
        if (pos_q == 2'd2 && is_pad) begin
          n_pad = 1'b1;
        end
      end
    end else begin
      grp.ent[0].out_byte = triple[23:16];
      grp.ent[1].out_byte = triple[15:8];
      grp.ent[2].out_byte = triple[7:0];
      grp.ent[0].out_last = fin && (dcnt == 3'd1);
      grp.ent[1].out_last = fin && (dcnt == 3'd2);
      grp.ent[2].out_last = fin && (dcnt == 3'd3);
      grp.cnt = dcnt;
      n_pos = 2'd0;
      n_acc = '0;
      n_pad = 1'b0;
    end
  end

  assign grp_o = grp;

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    acc_d  = acc_q;
    pad_d  = pad_q;
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      pos_d  = '0;
      acc_d  = '0;
      pad_d  = 1'b0;
    end else if (fire_i) begin
      if (fin) begin
        pos_d = '0;
        acc_d = '0;
        pad_d = 1'b0;
      end else begin
        pos_d = n_pos;
        acc_d = n_acc;
        pad_d = n_pad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b64sc_pkg::MODE_ENCODE;
      pos_q  <= '0;
      acc_q  <= '0;
      pad_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      pad_q  <= pad_d;
    end
  end

  `B64SC_ASSERT(a_last_restarts, clk_i, rst_ni, fire_i && item_i.last && !cfg_we_i |=> pos_q == 2'd0, "group not restarted after last request")
  `B64SC_ASSERT(a_pad_in_decode, clk_i, rst_ni, pad_q |-> (mode_q == b64sc_pkg::MODE_DECODE) && (pos_q == 2'd3), "pad mark outside a full decode group")
  `B64SC_NEVER(a_enc_no_error, clk_i, rst_ni, (mode_q == b64sc_pkg::MODE_ENCODE) && (grp.ent[0].length_error || grp.ent[1].length_error || grp.ent[2].length_error || grp.ent[3].length_error), "length error while encoding")
  `B64SC_NEVER(a_enc_pos, clk_i, rst_ni, (mode_q == b64sc_pkg::MODE_ENCODE) && (pos_q == 2'd3), "encode group position out of range")

endmodule

[rtl/core/b64sc_out_buf.sv]
// Result buffer: holds up to four results of one request and drains them in order.
// Depends on b64sc_pkg, b64sc_if and base64_stream_codec_defines.svh.
`include "base64_stream_codec_defines.svh"
module b64sc_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  b64sc_pkg::group_t  grp_i,
  output logic               can_load_o,
  b64sc_out_if.source        out_o
);

  b64sc_pkg::res_t [b64sc_pkg::MaxRes-1:0] ent_q;
  logic [b64sc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [b64sc_pkg::CntW-1:0] rd_q, rd_d;
  logic [b64sc_pkg::CntW-1:0] rd_inc;
  logic avail, pop, last_pop;
  b64sc_pkg::res_t head;

  assign rd_inc   = rd_q + b64sc_pkg::CntW'(1);
  assign avail    = (rd_q != cnt_q);
  assign pop      = avail && out_o.ready;
  assign last_pop = pop && (rd_inc == cnt_q);
  assign can_load_o = !avail || last_pop;
  assign head     = ent_q[rd_q[$clog2(b64sc_pkg::MaxRes)-1:0]];

  assign out_o.valid        = avail;
  assign out_o.out_byte     = head.out_byte;
  assign out_o.out_last     = head.out_last;
  assign out_o.length_error = head.length_error;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = grp_i.cnt;
      rd_d  = '0;
    end else if (pop) begin
      rd_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= grp_i.ent;
    end
  end

  `B64SC_ASSERT(a_rd_le_cnt, clk_i, rst_ni, rd_q <= cnt_q, "read pointer passed result count")
  `B64SC_NEVER(a_load_busy, clk_i, rst_ni, load_i && !can_load_o, "load while results still pending")
  `B64SC_ASSERT(a_stall_holds, clk_i, rst_ni, avail && !out_o.ready && !load_i |=> $stable(rd_q), "read pointer moved during stall")

endmodule

[rtl/core/base64_stream_codec.sv]
// Top level of the streaming base64 codec: input register, codec core, result buffer.
// Depends on b64sc_pkg, b64sc_if, b64sc_core and b64sc_out_buf.
//
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    in_byte[7:0], last
//   out_o     out   valid/ready    out_byte[7:0], out_last, length_error
//   cfg       in    cfg_we_i       cfg_wdata_i (mode)
//
// A request waits in the input register until the result buffer can load it;
// its results are then registered there and leave in order, one result per cycle
// while out_o is ready. A new request loads only once the single-read result
// buffer has drained; encoding mid-stream yields up to two results per byte.
// Reset clears the mode to encode and empties both registers; no clearing pass.
// A stall on out_o holds the buffer; the input register takes a new request as
// soon as the buffer drains its final result of the current request.
module base64_stream_codec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  b64sc_in_if.sink      in_i,
  b64sc_out_if.source   out_o
);

  logic              inv_q, inv_d;
  b64sc_pkg::item_t  item_q;
  logic              can_load;
  logic              fire;
  logic              take;
  b64sc_pkg::group_t grp;

  assign fire     = inv_q && can_load;
  assign in_i.ready = !inv_q || fire;
  assign take     = in_i.valid && in_i.ready;

  always_comb begin
    inv_d = inv_q;
    if (take) begin
      inv_d = 1'b1;
    end else if (fire) begin
      inv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else begin
      inv_q <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{in_byte: in_i.in_byte, last: in_i.last};
    end
  end

  b64sc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .grp_o       (grp)
  );

  b64sc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .grp_i      (grp),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
